// File: rtl/kdsm_pkg.sv
// ----------------------------------------------------------------------------
// kdsm_pkg: shared types and constants for the keyed deque
// Entry layout, operation and status codes, controller commands and the
// ring index helper used by the datapath.
// ----------------------------------------------------------------------------
package kdsm_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int ID_W     = 16;
    localparam int PRICE_W  = 32;
    localparam int STATUS_W = 2;

    localparam int S_FIELDS_W = OP_W + ID_W + PRICE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + ID_W + PRICE_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_UPDATE     = 3'd5,
        OP_FIND_MAX   = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // where the result entry comes from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_RDATA,
        SRC_BEST
    } res_src_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic     load;        // latch the accepted word
        logic     push;        // write new entry, grow
        logic     pop;         // read end entry, shrink
        logic     scan_start;  // rewind the walk
        logic     scan_step;   // issue next read, check previous
        logic     upd_wr;      // rewrite price of matched entry
        logic     res_load;    // fill output register
        res_src_t res_src;
        status_t  res_status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic hit;
        logic scan_done;
        logic out_free;
    } stat_t;

    // ring slot of the entry pos places behind front
    function automatic idx_t slot_of(idx_t front, idx_t pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/keyed_deque_with_search_and_max.sv
// ----------------------------------------------------------------------------
// keyed_deque_with_search_and_max: bounded deque of (id, price) entries
// Ring of 64 entries with push/pop at both ends, search and price update
// by id from the front, and highest-price lookup.
// ----------------------------------------------------------------------------
// One word in gives one word out. Words are taken one at a time: s_tready
// is high only while the block waits for work, and the result lands in an
// output register, so the next word can be taken while that result is still
// waiting on m_tready. Push, pop, refused and ignored words go from dispatch
// straight to the final step, which fills the output register. Search,
// update and find-max walk the held entries from the front through the
// single read port of the entry memory, one entry per cycle, before that
// final step; search and update stop at the first match. A full push
// returns status full and changes nothing; an empty store returns status
// empty for pop, search, update and max. Operation code 7 is a no-op with
// status ok. A result held on m_tready stalls the next word in its final
// step.
// No clearing pass is needed after reset: only held entries are ever read.
// ----------------------------------------------------------------------------
module keyed_deque_with_search_and_max (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] operation, [18:3] item_id, [50:19] price_cents, rest zero
    input  logic [kdsm_pkg::S_TDATA_W-1:0]  s_tdata,
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [17:2] entry_id, [49:18] entry_price,
    // [56:50] entry_count, rest zero
    output logic [kdsm_pkg::M_TDATA_W-1:0]  m_tdata
);

    kdsm_pkg::cmd_t  cmd;   // sequencer -> datapath
    kdsm_pkg::stat_t stat;  // datapath -> sequencer

    // sequencer: accept, dispatch, walk, hand off
    kdsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry ring, pointers, walk compare, output register
    kdsm_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // one word in flight: no second accept right after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous one still in work");

    // held count never goes past capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[56:50] <= kdsm_pkg::CNT_W'(kdsm_pkg::CAPACITY)))
        else $error("entry count beyond capacity");

    // full status only with a full ring
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == kdsm_pkg::STAT_FULL) |->
        (m_tdata[56:50] == kdsm_pkg::CNT_W'(kdsm_pkg::CAPACITY)))
        else $error("full status with ring not full");

    // empty status carries no entry and a zero count
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == kdsm_pkg::STAT_EMPTY) |->
        (m_tdata[49:2] == '0 && m_tdata[56:50] == '0))
        else $error("empty status with entry data or nonzero count");
`endif

endmodule

// File: rtl/kdsm_ctrl.sv
// ----------------------------------------------------------------------------
// kdsm_ctrl: operation sequencer
// Accepts one word at a time, dispatches it, runs the entry walk for
// search, update and max, then hands the result to the output register.
// ----------------------------------------------------------------------------
module kdsm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kdsm_pkg::stat_t   stat,
    output kdsm_pkg::cmd_t    cmd
);

    kdsm_pkg::state_t    state_reg, state_next;
    kdsm_pkg::status_t   res_status_reg, res_status_next;
    kdsm_pkg::res_src_t  res_src_reg, res_src_next;

    logic is_push, is_pop, is_keyed, stop_hit;

    assign is_push  = (stat.op == kdsm_pkg::OP_PUSH_BACK) ||
                      (stat.op == kdsm_pkg::OP_PUSH_FRONT);
    assign is_pop   = (stat.op == kdsm_pkg::OP_POP_FRONT) ||
                      (stat.op == kdsm_pkg::OP_POP_BACK);
    assign is_keyed = (stat.op == kdsm_pkg::OP_SEARCH) ||
                      (stat.op == kdsm_pkg::OP_UPDATE);
    assign stop_hit = is_keyed && stat.hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kdsm_pkg::ST_IDLE;
            res_status_reg <= kdsm_pkg::STAT_OK;
            res_src_reg    <= kdsm_pkg::SRC_ZERO;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_src_reg    <= res_src_next;
        end
    end

    // next state
    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_src_next    = res_src_reg;
        unique case (state_reg)
            kdsm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = kdsm_pkg::ST_DISPATCH;
                end
            end
            kdsm_pkg::ST_DISPATCH: begin
                state_next      = kdsm_pkg::ST_FINISH;
                res_status_next = kdsm_pkg::STAT_OK;
                res_src_next    = kdsm_pkg::SRC_ZERO;
                unique case (stat.op)
                    kdsm_pkg::OP_PUSH_BACK, kdsm_pkg::OP_PUSH_FRONT: begin
                        if (stat.full) begin
                            res_status_next = kdsm_pkg::STAT_FULL;
                        end
                    end
                    kdsm_pkg::OP_POP_FRONT, kdsm_pkg::OP_POP_BACK: begin
                        if (stat.empty) begin
                            res_status_next = kdsm_pkg::STAT_EMPTY;
                        end else begin
                            res_src_next = kdsm_pkg::SRC_RDATA;
                        end
                    end
                    kdsm_pkg::OP_SEARCH, kdsm_pkg::OP_UPDATE, kdsm_pkg::OP_FIND_MAX: begin
                        if (stat.empty) begin
                            res_status_next = kdsm_pkg::STAT_EMPTY;
                        end else begin
                            state_next = kdsm_pkg::ST_SCAN;
                        end
                    end
                    kdsm_pkg::OP_NONE: begin
                    end
                endcase
            end
            kdsm_pkg::ST_SCAN: begin
                priority if (stop_hit) begin
                    state_next      = kdsm_pkg::ST_FINISH;
                    res_status_next = kdsm_pkg::STAT_OK;
                    res_src_next    = kdsm_pkg::SRC_RDATA;
                end else if (stat.scan_done) begin
                    state_next = kdsm_pkg::ST_FINISH;
                    if (stat.op == kdsm_pkg::OP_FIND_MAX) begin
                        res_status_next = kdsm_pkg::STAT_OK;
                        res_src_next    = kdsm_pkg::SRC_BEST;
                    end else begin
                        res_status_next = kdsm_pkg::STAT_NOT_FOUND;
                        res_src_next    = kdsm_pkg::SRC_ZERO;
                    end
                end
            end
            kdsm_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = kdsm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            kdsm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            kdsm_pkg::ST_DISPATCH: begin
                cmd.push       = is_push && !stat.full;
                cmd.pop        = is_pop && !stat.empty;
                cmd.scan_start = (is_keyed || stat.op == kdsm_pkg::OP_FIND_MAX) &&
                                 !stat.empty;
            end
            kdsm_pkg::ST_SCAN: begin
                cmd.scan_step = !stop_hit;
                cmd.upd_wr    = stop_hit && (stat.op == kdsm_pkg::OP_UPDATE);
            end
            kdsm_pkg::ST_FINISH: begin
                cmd.res_load   = stat.out_free;
                cmd.res_src    = res_src_reg;
                cmd.res_status = res_status_reg;
            end
        endcase
    end

endmodule

// File: rtl/kdsm_dpath.sv
// ----------------------------------------------------------------------------
// kdsm_dpath: entry ring, pointers, walk logic and output register
// One-write, one-read entry memory with registered read data; the walk
// issues one read per cycle and checks the previous one.
// ----------------------------------------------------------------------------
module kdsm_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [kdsm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  kdsm_pkg::cmd_t                     cmd,
    output kdsm_pkg::stat_t                    stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kdsm_pkg::M_TDATA_W-1:0]     m_tdata
);

    kdsm_pkg::entry_t mem [kdsm_pkg::CAPACITY];

    kdsm_pkg::op_t                      op_reg;
    logic [kdsm_pkg::ID_W-1:0]          key_reg;
    logic [kdsm_pkg::PRICE_W-1:0]       price_reg;

    kdsm_pkg::idx_t   front_reg, front_next;
    kdsm_pkg::cnt_t   count_reg, count_next;
    kdsm_pkg::cnt_t   scan_pos_reg, scan_pos_next;
    logic             chk_valid_reg, chk_valid_next;
    kdsm_pkg::idx_t   chk_slot_reg, chk_slot_next;
    logic             best_valid_reg, best_valid_next;
    kdsm_pkg::entry_t best_reg, best_next;
    kdsm_pkg::entry_t rd_data_reg;
    logic             m_valid_reg, m_valid_next;
    logic [kdsm_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic             wr_en, rd_en, issue;
    kdsm_pkg::idx_t   wr_addr, rd_addr, front_dec, scan_slot;
    kdsm_pkg::entry_t wr_data, res_entry;
    kdsm_pkg::cnt_t   count_m1;

    assign front_dec = (front_reg == '0) ? kdsm_pkg::IDX_W'(kdsm_pkg::CAPACITY - 1)
                                         : front_reg - 1'b1;
    assign count_m1  = count_reg - 1'b1;
    assign scan_slot = kdsm_pkg::slot_of(front_reg, scan_pos_reg[kdsm_pkg::IDX_W-1:0]);
    assign issue     = cmd.scan_step && (scan_pos_reg < count_reg);

    // memory port muxes
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = front_dec;
        wr_data = '{id: key_reg, price: price_reg};
        if (cmd.push) begin
            wr_en = 1'b1;
            if (op_reg == kdsm_pkg::OP_PUSH_FRONT) begin
                wr_addr = front_dec;
            end else begin
                wr_addr = kdsm_pkg::slot_of(front_reg, count_reg[kdsm_pkg::IDX_W-1:0]);
            end
        end else if (cmd.upd_wr) begin
            wr_en   = 1'b1;
            wr_addr = chk_slot_reg;
            wr_data = '{id: rd_data_reg.id, price: price_reg};
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = scan_slot;
        if (cmd.pop) begin
            rd_en = 1'b1;
            if (op_reg == kdsm_pkg::OP_POP_FRONT) begin
                rd_addr = front_reg;
            end else begin
                rd_addr = kdsm_pkg::slot_of(front_reg, count_m1[kdsm_pkg::IDX_W-1:0]);
            end
        end else if (issue) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pointers, walk and result
    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        scan_pos_next   = scan_pos_reg;
        chk_valid_next  = chk_valid_reg;
        chk_slot_next   = chk_slot_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cmd.push) begin
            count_next = count_reg + 1'b1;
            if (op_reg == kdsm_pkg::OP_PUSH_FRONT) begin
                front_next = front_dec;
            end
        end
        if (cmd.pop) begin
            count_next = count_m1;
            if (op_reg == kdsm_pkg::OP_POP_FRONT) begin
                front_next = kdsm_pkg::slot_of(front_reg, kdsm_pkg::IDX_W'(1));
            end
        end

        if (cmd.scan_start) begin
            scan_pos_next   = '0;
            chk_valid_next  = 1'b0;
            best_valid_next = 1'b0;
        end
        if (cmd.scan_step) begin
            if (issue) begin
                scan_pos_next = scan_pos_reg + 1'b1;
            end
            chk_valid_next = issue;
            chk_slot_next  = scan_slot;
            // strict compare keeps the frontmost of equal maxima
            if (chk_valid_reg && (!best_valid_reg || rd_data_reg.price > best_reg.price)) begin
                best_valid_next = 1'b1;
                best_next       = rd_data_reg;
            end
        end

        unique case (cmd.res_src)
            kdsm_pkg::SRC_RDATA: res_entry = rd_data_reg;
            kdsm_pkg::SRC_BEST:  res_entry = best_reg;
            default:             res_entry = '0;
        endcase

        if (cmd.res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {{kdsm_pkg::M_PAD_W{1'b0}}, count_reg, res_entry.price,
                            res_entry.id, cmd.res_status};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg      <= '0;
            count_reg      <= '0;
            scan_pos_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            scan_pos_reg   <= scan_pos_next;
            chk_valid_reg  <= chk_valid_next;
            best_valid_reg <= best_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= kdsm_pkg::op_t'(s_tdata[kdsm_pkg::OP_W-1:0]);
            key_reg   <= s_tdata[kdsm_pkg::OP_W +: kdsm_pkg::ID_W];
            price_reg <= s_tdata[kdsm_pkg::OP_W + kdsm_pkg::ID_W +: kdsm_pkg::PRICE_W];
        end
        chk_slot_reg <= chk_slot_next;
        best_reg     <= best_next;
        m_data_reg   <= m_data_next;
    end

    assign stat.op        = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == kdsm_pkg::CNT_W'(kdsm_pkg::CAPACITY));
    assign stat.hit       = chk_valid_reg && (rd_data_reg.id == key_reg);
    assign stat.scan_done = !chk_valid_reg && (scan_pos_reg == count_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
